/* rtl/mbss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_pkg
// Shared types and constants of the masked byte signature scan.
// ----------------------------------------------------------------------------
package mbss_pkg;

   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned SIG_MAX_BYTES   = 16;
   localparam int unsigned PATTERN_W       = BYTE_W * SIG_MAX_BYTES;
   localparam int unsigned CARE_W          = SIG_MAX_BYTES;
   localparam int unsigned MATCH_OFFSET_W  = 32;
   localparam int unsigned CSR_INDEX_W     = 2;
   localparam int unsigned CSR_DATA_W      = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_CARE_MASK    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic [CARE_W-1:0]    care;
   } cfg_type;

   typedef struct packed {
      logic                      found;
      logic [MATCH_OFFSET_W-1:0] match_offset;
   } result_type;

endpackage

/* rtl/masked_byte_signature_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_signature_scan
// Finds the first window of a byte buffer that matches a masked signature.
// ----------------------------------------------------------------------------
// One byte is taken per request, one request per clock while req_tready is
// high. Each byte is shifted into a window of PATTERN_BYTES bytes and all
// positions are compared with the signature at once under the care mask; the
// first fully contained match is latched. The byte flagged by tlast queues
// one response: tuser is the found flag, tdata the start offset of the first
// match (zero when none). A mask without care bits reports found at offset
// zero. Responses sit in an output register with one skid entry, so req_tready
// drops only while two responses are held. The byte counter saturates at its
// OFFSET_BITS maximum, after which no new match is latched. Write the
// configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module masked_byte_signature_scan #(
   parameter int unsigned PATTERN_BYTES = 16,
   parameter int unsigned OFFSET_BITS   = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: [7:0] data_byte
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tlast,
   // response: [31:0] match_offset
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,
   // response: [0] found
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbss_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mbss_pkg::*;

   cfg_type    cfg;
   logic       take;
   logic       res_valid;
   result_type res;
   result_type rsp;

   assign take = req_tvalid & req_tready;

   mbss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbss_scan #(
      .PATTERN_BYTES (PATTERN_BYTES),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   mbss_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (req_tready),
      .in_data   (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   assign rsp_tdata = rsp.match_offset;
   assign rsp_tuser = rsp.found;

   a_stall_has_response: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request side stalled with no response held");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("response without match carries a nonzero offset");

   a_fill_skid: assert property (@(posedge clock) disable iff (reset)
      (take && req_tlast && rsp_tvalid && !rsp_tready) |=> !req_tready)
      else $error("second held response did not stall requests");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && !(take && req_tlast)) |=> !rsp_tvalid)
      else $error("response appeared without a last byte");

endmodule

/* rtl/mbss_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_csr
// Register file for the low and high halves of the signature and the care mask.
// ----------------------------------------------------------------------------
module mbss_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mbss_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output mbss_pkg::cfg_type               cfg
);
   import mbss_pkg::*;

   logic [CSR_DATA_W-1:0] pat_low_ff, pat_low_in;
   logic [CSR_DATA_W-1:0] pat_high_ff, pat_high_in;
   logic [CARE_W-1:0]     care_ff, care_in;
   logic                  write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   always_comb begin
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      care_in     = care_ff;
      if (write) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:  pat_low_in  = csr_wdata;
            CSR_PATTERN_HIGH: pat_high_in = csr_wdata;
            CSR_CARE_MASK:    care_in     = csr_wdata[CARE_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '0;
      end else begin
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         care_ff     <= care_in;
      end
   end

   assign cfg.pattern = {pat_high_ff, pat_low_ff};
   assign cfg.care    = care_ff;

endmodule

/* rtl/mbss_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_scan
// Byte window, byte counter and first-match latch; parallel masked compare.
// ----------------------------------------------------------------------------
module mbss_scan #(
   parameter int unsigned PATTERN_BYTES = 16,
   parameter int unsigned OFFSET_BITS   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [mbss_pkg::BYTE_W-1:0]   data_byte,
   input  logic                          last_byte,
   input  mbss_pkg::cfg_type             cfg,
   output logic                          res_valid,
   output mbss_pkg::result_type          res
);
   import mbss_pkg::*;

   logic [BYTE_W-1:0]      win_ff [PATTERN_BYTES];
   logic [BYTE_W-1:0]      win_in [PATTERN_BYTES];
   logic [BYTE_W-1:0]      win_new [PATTERN_BYTES];
   logic [OFFSET_BITS-1:0] count_ff, count_in, count_next;
   logic                   latched_ff, latched_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   saturated, enough, all_match, latch_now, no_care;
   logic                   latched_eff;
   logic [OFFSET_BITS-1:0] offset_eff;

   always_comb begin
      for (int i = 0; i < int'(PATTERN_BYTES) - 1; i++) begin
         win_new[i] = win_ff[i+1];
      end
      win_new[PATTERN_BYTES-1] = data_byte;
   end

   always_comb begin
      all_match = 1'b1;
      for (int i = 0; i < int'(PATTERN_BYTES); i++) begin
         if (cfg.care[i] && (win_new[i] != cfg.pattern[BYTE_W*i +: BYTE_W])) begin
            all_match = 1'b0;
         end
      end
   end

   assign saturated  = &count_ff;
   assign count_next = count_ff + 1'b1;
   assign enough     = count_next >= OFFSET_BITS'(PATTERN_BYTES);
   assign latch_now  = !saturated && !latched_ff && enough && all_match;
   assign no_care    = cfg.care[PATTERN_BYTES-1:0] == '0;
   assign latched_eff = latched_ff | latch_now;
   assign offset_eff  = latch_now ? (count_next - OFFSET_BITS'(PATTERN_BYTES)) : offset_ff;

   always_comb begin
      win_in     = win_ff;
      count_in   = count_ff;
      latched_in = latched_ff;
      offset_in  = offset_ff;
      if (take) begin
         if (last_byte) begin
            for (int i = 0; i < int'(PATTERN_BYTES); i++) begin
               win_in[i] = '0;
            end
            count_in   = '0;
            latched_in = 1'b0;
            offset_in  = '0;
         end else begin
            win_in     = win_new;
            count_in   = saturated ? count_ff : count_next;
            latched_in = latched_eff;
            offset_in  = offset_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(PATTERN_BYTES); i++) begin
            win_ff[i] <= '0;
         end
         count_ff   <= '0;
         latched_ff <= 1'b0;
         offset_ff  <= '0;
      end else begin
         win_ff     <= win_in;
         count_ff   <= count_in;
         latched_ff <= latched_in;
         offset_ff  <= offset_in;
      end
   end

   assign res_valid = take & last_byte;

   always_comb begin
      if (no_care) begin
         res.found        = 1'b1;
         res.match_offset = '0;
      end else if (latched_eff) begin
         res.found        = 1'b1;
         res.match_offset = MATCH_OFFSET_W'(offset_eff);
      end else begin
         res.found        = 1'b0;
         res.match_offset = '0;
      end
   end

endmodule

/* rtl/mbss_skid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbss_skid
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module mbss_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mbss_pkg::result_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mbss_pkg::result_type  out_data
);
   import mbss_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic       push, pop;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid & in_ready;
   assign pop      = out_valid_ff & out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
